// ===== hdl/dpur_pkg.sv =====
// Shared types and constants for the dual-pin UART receiver.
package dpur_pkg;

  // Default buffer depth; the write index wraps at this count
  localparam int BUFFER_DEPTH_DEF = 32;

  // Bits per frame after the start bit: eight data bits and one stop bit
  localparam logic [3:0] FRAME_BITS = 4'd9;

  // Level of a buffer entry that has never been written
  localparam logic [7:0] BUF_RESET_BYTE = 8'h01;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 2'd2;

  // Register reset values
  localparam logic [3:0] TICKS_PER_BIT_RST = 4'd3;
  localparam logic [3:0] START_DELAY_RST   = 4'd4;
  localparam logic [7:0] IDLE_TIMEOUT_RST  = 8'd105;
  localparam logic [3:0] SAMPLE_COUNT_RST  = 4'd4;

  // Pin that started the current frame
  localparam logic [1:0] PIN_NONE = 2'd0;
  localparam logic [1:0] PIN_A    = 2'd1;
  localparam logic [1:0] PIN_B    = 2'd2;

  // Configuration registers as seen by the receiver core
  typedef struct packed {
    logic [3:0] ticks_per_bit;
    logic [3:0] start_delay;
    logic [7:0] idle_timeout;
  } cfg_t;

endpackage

// ===== hdl/dual_pin_uart_receiver_unit.sv =====
// Top level of the dual-pin UART receiver.
//
// Each input word is one oversample tick (three per bit at the default
// settings) carrying both pin levels, a frame acknowledge and a buffer read
// index; each accepted word yields exactly one result word. A word is taken
// every cycle while the output queue has room: the receiver state and the
// byte buffer advance at intake, the result sits in a registered stage (the
// buffer's registered read port sets this), and a two-entry output queue
// lets intake go on while a result waits. The buffer needs no clearing
// pass: per-entry valid bits make unwritten entries read as 0x01 right
// after reset. Registers are to be written through the configuration
// port only while the block is idle; the block itself does not enforce it.
module dual_pin_uart_receiver_unit #(
  parameter int BUFFER_DEPTH = dpur_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            rx_pin_a,
  input  logic                            rx_pin_b,
  input  logic                            frame_ack,
  input  logic [AW-1:0]                   read_index,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            frame_ready,
  output logic [AW-1:0]                   byte_count,
  output logic                            byte_stored,
  output logic [7:0]                      stored_byte,
  output logic [7:0]                      read_data,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpur_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int RW = 1 + AW + 1 + 8 + 8;

  dpur_pkg::cfg_t cfg;
  logic           s_valid;
  logic           step;
  logic           q_ready;
  logic           r_frame_ready;
  logic [AW-1:0]  r_byte_count;
  logic           r_byte_stored;
  logic [7:0]     r_stored_byte;
  logic [7:0]     r_read_data;
  logic [RW-1:0]  q_out;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_bit <= dpur_pkg::TICKS_PER_BIT_RST;
      cfg.start_delay   <= dpur_pkg::START_DELAY_RST;
      cfg.idle_timeout  <= dpur_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpur_pkg::CFG_TICKS_PER_BIT: cfg.ticks_per_bit <= cfg_data[3:0];
        dpur_pkg::CFG_START_DELAY:   cfg.start_delay   <= cfg_data[3:0];
        dpur_pkg::CFG_IDLE_TIMEOUT:  cfg.idle_timeout  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Result stage: full until the queue takes it
  assign in_ready = !s_valid || q_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (step) begin
      s_valid <= 1'b1;
    end else if (q_ready) begin
      s_valid <= 1'b0;
    end
  end

  dpur_rx #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_rx (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cfg         (cfg),
    .rx_pin_a    (rx_pin_a),
    .rx_pin_b    (rx_pin_b),
    .frame_ack   (frame_ack),
    .read_index  (read_index),
    .frame_ready (r_frame_ready),
    .byte_count  (r_byte_count),
    .byte_stored (r_byte_stored),
    .stored_byte (r_stored_byte),
    .read_data   (r_read_data)
  );

  dpur_outq #(
    .W (RW)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (s_valid && q_ready),
    .push_data  ({r_frame_ready, r_byte_count, r_byte_stored, r_stored_byte, r_read_data}),
    .push_ready (q_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (q_out)
  );

  assign {frame_ready, byte_count, byte_stored, stored_byte, read_data} = q_out;

endmodule

// ===== hdl/dpur_rx.sv =====
// Receiver core: bit sampling, frame timeout and the byte buffer.
module dpur_rx #(
  parameter int BUFFER_DEPTH = dpur_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  dpur_pkg::cfg_t       cfg,
  input  logic                 rx_pin_a,
  input  logic                 rx_pin_b,
  input  logic                 frame_ack,
  input  logic [AW-1:0]        read_index,
  output logic                 frame_ready,
  output logic [AW-1:0]        byte_count,
  output logic                 byte_stored,
  output logic [7:0]           stored_byte,
  output logic [7:0]           read_data
);

  localparam logic [AW:0]   DepthW   = (AW+1)'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LastIdx  = AW'(BUFFER_DEPTH - 1);

  // Receiver state
  logic        receiving, receiving_next;
  logic [1:0]  active_pin, active_pin_next;
  logic [3:0]  sample_count, sample_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_data, shift_data_next;
  logic [AW-1:0] write_count, write_count_next;
  logic [7:0]  timeout_count, timeout_count_next;
  logic        ready_flag, ready_flag_next;

  // Buffer and read side
  logic [7:0]          mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] valid;
  logic [7:0]          rd_q;
  logic                vld_q;
  logic                byp_q;

  logic          store;
  logic          pin_bit;
  logic [3:0]    sc_dec;
  logic [3:0]    bc_dec;
  logic [AW-1:0] wc_base;
  logic [AW-1:0] wc_inc;
  logic [7:0]    to_base;
  logic [AW:0]   ridx_ext;
  logic [AW-1:0] ridx_mod;

  assign sc_dec   = sample_count - 4'd1;
  assign bc_dec   = bit_count - 4'd1;
  // Acknowledge clears the count before anything else this tick
  assign wc_base  = frame_ack ? '0 : write_count;
  assign wc_inc   = (wc_base == LastIdx) ? '0 : wc_base + AW'(1);
  // Fold the read index into the buffer range
  assign ridx_ext = {1'b0, read_index};
  assign ridx_mod = (ridx_ext >= DepthW) ? AW'(ridx_ext - DepthW) : read_index;

  // Data bit from the pin that opened the frame
  always_comb begin
    case (active_pin)
      dpur_pkg::PIN_A: pin_bit = rx_pin_a;
      dpur_pkg::PIN_B: pin_bit = rx_pin_b;
      default:         pin_bit = 1'b0;
    endcase
  end

  // One tick of the receiver
  always_comb begin
    receiving_next     = receiving;
    active_pin_next    = active_pin;
    sample_count_next  = sample_count;
    bit_count_next     = bit_count;
    shift_data_next    = shift_data;
    write_count_next   = wc_base;
    ready_flag_next    = frame_ack ? 1'b0 : ready_flag;
    store              = 1'b0;

    if (receiving) begin
      sample_count_next = sc_dec;
      if (sc_dec == 4'd0) begin
        sample_count_next = cfg.ticks_per_bit;
        bit_count_next    = bc_dec;
        if (bc_dec == 4'd0) begin
          // stop bit on either pin; dropped while a frame is pending
          receiving_next = 1'b0;
          if ((rx_pin_a | rx_pin_b) && !ready_flag_next) begin
            store = 1'b1;
          end
        end else begin
          shift_data_next = {pin_bit, shift_data[7:1]};
        end
      end
    end else if (!rx_pin_b) begin
      active_pin_next   = dpur_pkg::PIN_B;
      receiving_next    = 1'b1;
      sample_count_next = cfg.start_delay;
      bit_count_next    = dpur_pkg::FRAME_BITS;
    end else if (!rx_pin_a) begin
      active_pin_next   = dpur_pkg::PIN_A;
      receiving_next    = 1'b1;
      sample_count_next = cfg.start_delay;
      bit_count_next    = dpur_pkg::FRAME_BITS;
    end

    if (store) begin
      write_count_next = wc_inc;
    end

    // Idle timeout: rearmed by a stored byte, then counts this tick
    to_base            = store ? cfg.idle_timeout : timeout_count;
    timeout_count_next = to_base;
    if (to_base != 8'd0) begin
      timeout_count_next = to_base - 8'd1;
      if (to_base == 8'd1) begin
        ready_flag_next = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      receiving     <= 1'b0;
      active_pin    <= dpur_pkg::PIN_NONE;
      sample_count  <= dpur_pkg::SAMPLE_COUNT_RST;
      bit_count     <= 4'd0;
      shift_data    <= 8'd0;
      write_count   <= '0;
      timeout_count <= 8'd0;
      ready_flag    <= 1'b0;
    end else if (step) begin
      receiving     <= receiving_next;
      active_pin    <= active_pin_next;
      sample_count  <= sample_count_next;
      bit_count     <= bit_count_next;
      shift_data    <= shift_data_next;
      write_count   <= write_count_next;
      timeout_count <= timeout_count_next;
      ready_flag    <= ready_flag_next;
    end
  end

  // Entries not yet written read as the reset byte
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (step && store) begin
      valid[wc_base] <= 1'b1;
    end
  end

  // Buffer memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (step && store) begin
      mem[wc_base] <= shift_data;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rd_q <= mem[ridx_mod];
    end
  end

  // Per-tick result; bypass covers a read of the entry written this tick
  always_ff @(posedge clk) begin
    if (step) begin
      vld_q       <= valid[ridx_mod];
      byp_q       <= store && (wc_base == ridx_mod);
      byte_stored <= store;
      stored_byte <= store ? shift_data : 8'd0;
    end
  end

  // State holds while the result waits, so it is read out directly
  assign frame_ready = ready_flag;
  assign byte_count  = write_count;
  assign read_data   = byp_q ? stored_byte :
                       (vld_q ? rd_q : dpur_pkg::BUF_RESET_BYTE);

endmodule

// ===== hdl/dpur_outq.sv =====
// Two-entry output queue that decouples result delivery from intake.
module dpur_outq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [1:0]   cnt, cnt_next;
  logic [W-1:0] e0, e1;
  logic         pop;
  logic         wr_head;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (cnt != 2'd0);
  assign push_ready = (cnt != 2'd2);
  assign out_data   = e0;
  // New word lands at the head when the queue is or becomes empty
  assign wr_head    = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Entries shift toward the head on a pop
  always_ff @(posedge clk) begin
    if (push && wr_head) begin
      e0 <= push_data;
    end else if (pop) begin
      e0 <= e1;
    end
    if (push && !wr_head) begin
      e1 <= push_data;
    end
  end

endmodule

// ===== hdl/dpur_check.sv =====
// Port-level checks for the dual-pin UART receiver, bound to the top level.
module dpur_check #(
  parameter int BUFFER_DEPTH = dpur_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            frame_ready,
  input logic [AW-1:0]                   byte_count,
  input logic                            byte_stored,
  input logic [7:0]                      stored_byte,
  input logic [7:0]                      read_data
);

  // Out of reset the block is empty and ready for a word
  a_reset_empty: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not empty after reset");

  // Every accepted word is followed by out_valid once it has passed the result stage
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing after intake");

  // A word with no stored byte reports a zero byte
  a_stored_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_stored |-> stored_byte == 8'd0)
    else $error("stored_byte set without a store");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_ready)
      && $stable(byte_count) && $stable(byte_stored)
      && $stable(stored_byte) && $stable(read_data))
    else $error("stalled result changed");

endmodule

bind dual_pin_uart_receiver_unit dpur_check #(
  .BUFFER_DEPTH (BUFFER_DEPTH)
) u_dpur_check (.*);
